FILE: rtl/median_filter_3x3_unit_assert.svh
// Assertion macros for the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_UNIT_ASSERT_SVH
`define MEDIAN_FILTER_3X3_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MF3_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MF3_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MF3_ASSERT(lbl, clk, rst, prop, msg)
`define MF3_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/mf3_pkg.sv
package mf3_pkg;

  localparam int MAX_LINE  = 1024;
  localparam int MAX_LINES = 4096;
  localparam int MIN_DIM   = 3;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_LINE);
  localparam int ROW_W  = $clog2(MAX_LINES);
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 13;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int WIN_SIZE     = 9;
  localparam int WIN_HIST     = 6;
  localparam int MID_IDX      = WIN_SIZE / 2;
  localparam int FIRST_ROUNDS = 2;
  localparam int LAST_ROUNDS  = 3;

  typedef enum logic [0:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_LINE_COUNT  = 1'b1
  } cfg_reg_t;

  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [LEN_W-1:0] line_length;
    logic [CNT_W-1:0] line_count;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    win_t             v;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } stage_t;

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] res;
    if (v < LEN_W'(MIN_DIM)) begin
      res = LEN_W'(MIN_DIM);
    end else if (v > LEN_W'(MAX_LINE)) begin
      res = LEN_W'(MAX_LINE);
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v < CNT_W'(MIN_DIM)) begin
      res = CNT_W'(MIN_DIM);
    end else if (v > CNT_W'(MAX_LINES)) begin
      res = CNT_W'(MAX_LINES);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Odd-even transposition rounds: an even phase then an odd phase each.
  function automatic win_t sort_rounds(win_t v_in, int unsigned rounds);
    win_t             v;
    logic [PIX_W-1:0] t;
    v = v_in;
    for (int r = 0; r < rounds; r++) begin
      for (int k = 0; k + 1 < WIN_SIZE; k += 2) begin
        if (v[k] > v[k+1]) begin
          t      = v[k];
          v[k]   = v[k+1];
          v[k+1] = t;
        end
      end
      for (int k = 1; k + 1 < WIN_SIZE; k += 2) begin
        if (v[k] > v[k+1]) begin
          t      = v[k];
          v[k]   = v[k+1];
          v[k+1] = t;
        end
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/mf3_ram.sv
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mf3_cfg.sv
module mf3_cfg
  import mf3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [LEN_W-1:0] line_length;
  logic [CNT_W-1:0] line_count;
  logic             restart;
  logic             wr;
  cfg_reg_t         sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign sel     = cfg_reg_t'(paddr[2]);
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_W'(MAX_LINE);
      line_count  <= CNT_W'(1024);
    end else begin
      if (wr) begin
        unique case (sel)
          REG_LINE_LENGTH: line_length <= clamp_len(pwdata[LEN_W-1:0]);
          REG_LINE_COUNT:  line_count  <= clamp_cnt(pwdata[CNT_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (sel)
      REG_LINE_LENGTH: prdata = DATA_W'(line_length);
      REG_LINE_COUNT:  prdata = DATA_W'(line_count);
      default:         prdata = '0;
    endcase
  end

  // counters restart on write; config written only while idle is up to the user
  assign cfg.line_length = line_length;
  assign cfg.line_count  = line_count;
  assign cfg.restart     = restart;

endmodule

FILE: rtl/mf3_window.sv
`include "median_filter_3x3_unit_assert.svh"

module mf3_window
  import mf3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] pixel,
  output stage_t           s2
);

  logic             accept;
  logic [COL_W-1:0] col_counter;
  logic [ROW_W-1:0] row_counter;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             end_of_line;
  logic             end_of_frame;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;

  logic [2*PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;
  logic               ram_we;

  logic [WIN_HIST-1:0][PIX_W-1:0] window;
  win_t   v;
  logic   interior;
  logic   s1_last;
  stage_t s2_next;

  assign accept = in_valid && advance;

  assign end_of_line  = (LEN_W'(col_counter) + LEN_W'(1)) >= cfg.line_length;
  assign end_of_frame = (CNT_W'(row_counter) + CNT_W'(1)) >= cfg.line_count;

  always_comb begin
    col_next = col_counter + COL_W'(1);
    row_next = row_counter;
    if (end_of_line) begin
      col_next = '0;
      row_next = end_of_frame ? '0 : row_counter + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col_counter <= '0;
      row_counter <= '0;
    end else if (accept) begin
      col_counter <= col_next;
      row_counter <= row_next;
    end
  end

  // Line stores: upper in the high byte, middle in the low byte.
  assign ram_we = s1_valid && advance;

  mf3_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_LINE)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_col),
    .wdata({mid, s1_pixel}),
    .re   (accept),
    .raddr(col_counter),
    .rdata(ram_rdata)
  );

  assign top = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_col   <= col_counter;
      s1_row   <= row_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (ram_we) begin
      window <= {s1_pixel, mid, top, window[5], window[4], window[3]};
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_HIST; i++) begin
      v[i] = window[i];
    end
    v[6] = top;
    v[7] = mid;
    v[8] = s1_pixel;
  end

  assign interior = (s1_row >= ROW_W'(2)) && (s1_col >= COL_W'(2));
  assign s1_last  = ((CNT_W'(s1_row) + CNT_W'(1)) >= cfg.line_count) &&
                    ((LEN_W'(s1_col) + LEN_W'(1)) >= cfg.line_length);

  always_comb begin
    s2_next.valid = s1_valid && interior;
    s2_next.v     = sort_rounds(v, FIRST_ROUNDS);
    s2_next.row   = s1_row - ROW_W'(1);
    s2_next.col   = s1_col - COL_W'(1);
    s2_next.last  = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (advance) begin
      s2.valid <= s2_next.valid;
    end
    if (advance) begin
      s2.v    <= s2_next.v;
      s2.row  <= s2_next.row;
      s2.col  <= s2_next.col;
      s2.last <= s2_next.last;
    end
  end

  `MF3_ASSERT(a_ram_no_collide, clk, rst,
              (ram_we && accept) |-> (s1_col != col_counter),
              "line store read and write hit the same column")
  `MF3_ASSERT(a_s1_holds, clk, rst,
              (s1_valid && !advance) |=> (s1_valid && $stable(s1_col)),
              "stage 1 word lost during stall")
  `MF3_ASSERT(a_col_in_line, clk, rst,
              1'b1 |-> (LEN_W'(col_counter) < cfg.line_length || cfg.restart ||
                        $past(cfg.restart)),
              "column counter beyond line length")

endmodule

FILE: rtl/mf3_sort.sv
`include "median_filter_3x3_unit_assert.svh"

module mf3_sort
  import mf3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  stage_t           s2,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] median,
  output logic [ROW_W-1:0] row,
  output logic [COL_W-1:0] col,
  output logic             last_of_frame
);

  win_t sorted;

  assign advance = !out_valid || out_ready;
  assign sorted  = sort_rounds(s2.v, LAST_ROUNDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      median        <= sorted[MID_IDX];
      row           <= s2.row;
      col           <= s2.col;
      last_of_frame <= s2.last;
    end
  end

  `MF3_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid, "result pending after reset")
  `MF3_ASSERT(a_interior_only, clk, rst, out_valid |-> (row != '0 && col != '0), "border position produced a result")

endmodule

FILE: rtl/median_filter_3x3_unit.sv
// 3x3 median filter over a raster-ordered stream of 8-bit pixels.
// Input channel (in_valid/in_ready, pixel): one pixel word per accept, going
// along each line, line after line. Output channel (out_valid/out_ready):
// median, row, col and last_of_frame for each interior position only; border
// pixels are stored for later windows but give no word.
// APB port: line_length at 0x0, line_count at 0x4. A write restarts the image
// at row 0, column 0; write only while the block is idle.
// Throughput: one pixel per cycle while the output is not stalled. A pixel
// passes the line store read into the input stage, the first rounds of the
// sorting network into s2, and the remaining rounds into the output register.
// The two line stores share one 1024 x 16 RAM; its single read and write
// per cycle set the one-pixel-per-cycle rate.
// Reset clears the counters, the window and all valid flags; line stores are
// not cleared and are fully rewritten before any result uses them.
// When out_ready is low with a result held, the whole pipeline stalls and
// in_ready drops; no word is lost or repeated.
module median_filter_3x3_unit
  import mf3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  median,
  output logic [ROW_W-1:0]  row,
  output logic [COL_W-1:0]  col,
  output logic              last_of_frame
);

  cfg_t   cfg;
  stage_t s2;
  logic   advance;

  assign in_ready = advance;

  mf3_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  mf3_window u_window (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .in_valid(in_valid),
    .pixel   (pixel),
    .s2      (s2)
  );

  mf3_sort u_sort (
    .clk          (clk),
    .rst          (rst),
    .s2           (s2),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median       (median),
    .row          (row),
    .col          (col),
    .last_of_frame(last_of_frame)
  );

endmodule

FILE: tb/tb_median_filter_3x3_unit.sv
module tb_median_filter_3x3_unit;
  import mf3_pkg::*;

  localparam int LIMIT = 200_000;

  typedef struct {
    logic [PIX_W-1:0] med;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic             lst;
  } median_word_t;

  typedef struct {
    logic [PIX_W-1:0] px;
    bit               drain;
  } pixel_word_t;

  typedef enum int {PX_UNIFORM, PX_EXTREME, PX_CLUSTER} px_style_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  pixel = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  median;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic              last_of_frame;

  median_filter_3x3_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .median(median), .row(row), .col(col), .last_of_frame(last_of_frame)
  );

  always #6 clk = ~clk;

  // filter state as seen by the checker
  logic [PIX_W-1:0] up_ln  [MAX_LINE];
  logic [PIX_W-1:0] mid_ln [MAX_LINE];
  logic [PIX_W-1:0] band   [WIN_HIST];
  logic [COL_W-1:0] cur_col = '0;
  logic [ROW_W-1:0] cur_row = '0;
  logic [LEN_W-1:0] len_cfg = LEN_W'(1024);
  logic [CNT_W-1:0] cnt_cfg = CNT_W'(1024);

  median_word_t medians_due[$];
  pixel_word_t  pend[$];
  median_word_t got_w;

  int  mism_cnt = 0;
  int  cyc = 0;
  bit  px_taken = 1'b0;
  bit  calm = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  src_gap = 0;
  int  sink_gap = 0;

  task automatic report_err(string msg);
    if (mism_cnt < 200) $display("ERROR @%0d: %s", cyc, msg);
    mism_cnt++;
  endtask

  function automatic logic [PIX_W-1:0] median9(logic [WIN_SIZE-1:0][PIX_W-1:0] s);
    logic [PIX_W-1:0] t;
    int j;
    for (int i = 1; i < WIN_SIZE; i++) begin
      t = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > t) begin
        s[j+1] = s[j];
        j--;
      end
      s[j+1] = t;
    end
    return s[MID_IDX];
  endfunction

  task automatic step_filter(logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] ctr;
    logic [WIN_SIZE-1:0][PIX_W-1:0] nb;
    median_word_t w;
    int c;
    int r;
    c = int'(cur_col);
    r = int'(cur_row);
    top = up_ln[c];
    ctr = mid_ln[c];
    up_ln[c] = ctr;
    mid_ln[c] = px;
    if (r >= 2 && c >= 2) begin
      nb = {px, ctr, top, band[5], band[4], band[3], band[2], band[1], band[0]};
      w.med = median9(nb);
      w.r = ROW_W'(r - 1);
      w.c = COL_W'(c - 1);
      w.lst = (r + 1 >= int'(cnt_cfg)) && (c + 1 >= int'(len_cfg));
      medians_due.push_back(w);
    end
    band[0] = band[3];
    band[1] = band[4];
    band[2] = band[5];
    band[3] = top;
    band[4] = ctr;
    band[5] = px;
    if (c + 1 >= int'(len_cfg)) begin
      cur_col = '0;
      cur_row = (r + 1 >= int'(cnt_cfg)) ? '0 : ROW_W'(r + 1);
    end else begin
      cur_col = COL_W'(c + 1);
    end
  endtask

  function automatic void write_dims(cfg_reg_t idx, logic [DATA_W-1:0] v);
    int x;
    if (idx == REG_LINE_LENGTH) begin
      x = int'(v[LEN_W-1:0]);
      len_cfg = (x < MIN_DIM) ? LEN_W'(MIN_DIM) :
                (x > MAX_LINE) ? LEN_W'(MAX_LINE) : LEN_W'(x);
    end else begin
      x = int'(v[CNT_W-1:0]);
      cnt_cfg = (x < MIN_DIM) ? CNT_W'(MIN_DIM) :
                (x > MAX_LINES) ? CNT_W'(MAX_LINES) : CNT_W'(x);
    end
    cur_col = '0;
    cur_row = '0;
  endfunction

  // write, then read the register back
  task automatic apb_write(cfg_reg_t idx, logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    write_dims(idx, v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (idx == REG_LINE_LENGTH) ? DATA_W'(len_cfg) : DATA_W'(cnt_cfg);
    if (prdata !== want)
      report_err($sformatf("read back %0d, want %0d", prdata, want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // junk in the upper bits now and then; only the register width counts
  function automatic logic [DATA_W-1:0] with_junk(int raw, int w);
    logic [DATA_W-1:0] m;
    m = (32'h1 << w) - 1;
    if ($urandom_range(0, 2) == 0) return ($urandom & ~m) | (raw & m);
    return raw;
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (pend.size() != 0 || in_valid || medians_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(px_style_t style, logic [PIX_W-1:0] base);
    case (style)
      PX_UNIFORM: return $urandom_range(0, 255);
      PX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:    return base + PIX_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic queue_pixels(int n, px_style_t style, int drain_at);
    logic [PIX_W-1:0] base;
    pixel_word_t it;
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      it.px = pick_pixel(style, base);
      it.drain = (i == drain_at);
      pend.push_back(it);
    end
  endtask

  task automatic queue_fixed(logic [PIX_W-1:0] px);
    pixel_word_t it;
    it.px = px;
    it.drain = 1'b0;
    pend.push_back(it);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || px_taken) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (pend.size() > 0 && (!pend[0].drain || medians_due.size() == 0)) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          pixel <= pend[0].px;
          void'(pend.pop_front());
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_go && !hold_done && out_valid) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    px_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (medians_due.size() == 0) begin
          report_err($sformatf("unexpected word median=%0d row=%0d col=%0d last=%0b",
                               median, row, col, last_of_frame));
        end else begin
          got_w = medians_due.pop_front();
          if (median !== got_w.med)
            report_err($sformatf("median %0d, want %0d (row %0d col %0d)",
                                 median, got_w.med, got_w.r, got_w.c));
          if (row !== got_w.r)
            report_err($sformatf("row %0d, want %0d", row, got_w.r));
          if (col !== got_w.c)
            report_err($sformatf("col %0d, want %0d (row %0d)", col, got_w.c, got_w.r));
          if (last_of_frame !== got_w.lst)
            report_err($sformatf("last_of_frame %0b, want %0b (row %0d col %0d)",
                                 last_of_frame, got_w.lst, got_w.r, got_w.c));
        end
      end
      if (in_valid && in_ready) step_filter(pixel);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n_items;
    int which;
    int raw;
    int n;
    for (int i = 0; i < MAX_LINE; i++) begin
      up_ln[i] = '0;
      mid_ln[i] = '0;
    end
    for (int i = 0; i < WIN_HIST; i++) band[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // smallest image: flat white, then mixed extremes on the next frame
    repeat (4) @(negedge clk);
    apb_write(REG_LINE_LENGTH, 32'd3);
    apb_write(REG_LINE_COUNT, 32'd3);
    repeat (9) queue_fixed(8'hFF);
    queue_fixed(8'h00); queue_fixed(8'hFF); queue_fixed(8'h01);
    queue_fixed(8'hFE); queue_fixed(8'h80); queue_fixed(8'h7F);
    queue_fixed(8'h00); queue_fixed(8'hFF); queue_fixed(8'h40);
    // below-range values clamp up
    wait_idle();
    apb_write(REG_LINE_LENGTH, 32'd1);
    apb_write(REG_LINE_COUNT, 32'd0);
    for (int i = 0; i < 7; i++) queue_fixed(PIX_W'(i * 37));

    // above-range values clamp down to the widest line and most lines
    wait_idle();
    apb_write(REG_LINE_LENGTH, with_junk(2047, LEN_W));
    apb_write(REG_LINE_COUNT, with_junk(8191, CNT_W));
    queue_pixels(16, PX_UNIFORM, -1);

    // long receiver stall once results flow, then a drain pause
    wait_idle();
    apb_write(REG_LINE_LENGTH, 32'd4);
    apb_write(REG_LINE_COUNT, 32'd8);
    hold_go = 1'b1;
    queue_pixels(40, PX_UNIFORM, 30);

    n_items = 0;
    while (n_items < 400) begin
      wait_idle();
      which = $urandom_range(0, 3);
      if (which[0]) begin
        raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        apb_write(REG_LINE_LENGTH, with_junk(raw, LEN_W));
      end
      if (which[1]) begin
        raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        apb_write(REG_LINE_COUNT, with_junk(raw, CNT_W));
      end
      n = $urandom_range(20, 70);
      queue_pixels(n, px_style_t'($urandom_range(0, 2)),
                   ($urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : -1);
      n_items += n;
    end

    wait_idle();
    calm = 1'b1;
    apb_write(REG_LINE_LENGTH, 32'd4);
    apb_write(REG_LINE_COUNT, 32'd4);
    queue_pixels(48, PX_UNIFORM, -1);

    wait_idle();
    if (mism_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
